>>> src/msp_pkg.sv
package msp_pkg;

  // Widths of the configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_AUX_CHANNEL    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STATUS_COMMAND = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RC_COMMAND     = 2'd2;

  // Reset values of the registers.
  localparam logic [3:0]  AUX_CHANNEL_RESET    = 4'd0;
  localparam logic [15:0] STATUS_COMMAND_RESET = 16'd101;
  localparam logic [15:0] RC_COMMAND_RESET     = 16'd105;

  // Frame bytes.
  localparam logic [7:0] CHAR_START = 8'h24;  // '$'
  localparam logic [7:0] CHAR_V2    = 8'h58;  // 'X'
  localparam logic [7:0] CHAR_RESP  = 8'h3E;  // '>'

  // CRC-8 DVB-S2.
  localparam logic [7:0] CRC_POLY = 8'hD5;

  // Decoding constants.
  localparam logic [15:0] STATUS_MIN_SIZE = 16'd10;
  localparam logic [15:0] ARMED_BYTE_POS  = 16'd6;
  localparam logic [15:0] AUX_THRESHOLD   = 16'd1500;
  localparam int          RC_WORD_BASE    = 3;

  // Only channel words 4 through 18 can ever be selected by a 4-bit aux channel
  // (word 3 + aux, aux from 1 to 15), so only those payload bytes are kept.
  localparam int          NUM_WORDS      = 15;
  localparam logic [15:0] WORD_FIRST_POS = 16'(2 * (RC_WORD_BASE + 1));
  localparam logic [15:0] WORD_END_POS   = 16'(2 * (RC_WORD_BASE + 1 + NUM_WORDS));

  // Depth of the queue between the parser and the event unit.
  localparam int JOB_QUEUE_DEPTH = 2;

  // Result kinds.
  localparam logic EV_ARMED = 1'b0;
  localparam logic EV_AUX   = 1'b1;

  typedef enum logic [9:0] {
    PH_IDLE    = 10'b00_0000_0001,
    PH_HDR_X   = 10'b00_0000_0010,
    PH_HDR_DIR = 10'b00_0000_0100,
    PH_FLAG    = 10'b00_0000_1000,
    PH_CMD_LO  = 10'b00_0001_0000,
    PH_CMD_HI  = 10'b00_0010_0000,
    PH_SZ_LO   = 10'b00_0100_0000,
    PH_SZ_HI   = 10'b00_1000_0000,
    PH_PAYLOAD = 10'b01_0000_0000,
    PH_CRC     = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic [3:0]  aux_channel;
    logic [15:0] status_command;
    logic [15:0] rc_command;
  } cfg_t;

  // One decoded frame, handed from the parser to the event unit.
  typedef struct packed {
    logic kind;   // EV_ARMED or EV_AUX
    logic level;  // decoded armed or aux-high level
  } job_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

>>> src/msp_front.sv
module msp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         rx_byte,
  input  msp_pkg::cfg_t      cfg,
  output logic               job_push,
  output msp_pkg::job_t      job
);

  msp_pkg::phase_t phase;
  msp_pkg::phase_t phase_next;

  logic [7:0]  crc;
  logic [15:0] cmd;
  logic [15:0] size;
  logic [15:0] pos;
  logic        armed_bit;
  logic [15:0] words [msp_pkg::NUM_WORDS];

  logic [15:0] size_full;
  logic [15:0] pos_inc;
  logic [15:0] pos_off;
  logic        in_word_range;
  logic [3:0]  word_idx;
  logic [15:0] aux_word;
  logic [15:0] rc_min_size;
  logic        crc_ok;

  assign size_full     = {rx_byte, size[7:0]};
  assign pos_inc       = pos + 16'd1;
  assign pos_off       = pos - msp_pkg::WORD_FIRST_POS;
  assign in_word_range = (pos >= msp_pkg::WORD_FIRST_POS) && (pos < msp_pkg::WORD_END_POS);
  assign word_idx      = (cfg.aux_channel == 4'd0) ? 4'd0 : cfg.aux_channel - 4'd1;
  assign aux_word      = words[word_idx];
  assign rc_min_size   = 16'(({12'd0, cfg.aux_channel} + 16'(msp_pkg::RC_WORD_BASE + 1)) << 1);
  assign crc_ok        = (rx_byte == crc);

  always_comb begin
    phase_next = phase;
    unique case (phase)
      msp_pkg::PH_IDLE: begin
        if (rx_byte == msp_pkg::CHAR_START) phase_next = msp_pkg::PH_HDR_X;
      end
      msp_pkg::PH_HDR_X: begin
        phase_next = (rx_byte == msp_pkg::CHAR_V2) ? msp_pkg::PH_HDR_DIR : msp_pkg::PH_IDLE;
      end
      msp_pkg::PH_HDR_DIR: begin
        phase_next = (rx_byte == msp_pkg::CHAR_RESP) ? msp_pkg::PH_FLAG : msp_pkg::PH_IDLE;
      end
      msp_pkg::PH_FLAG:   phase_next = msp_pkg::PH_CMD_LO;
      msp_pkg::PH_CMD_LO: phase_next = msp_pkg::PH_CMD_HI;
      msp_pkg::PH_CMD_HI: phase_next = msp_pkg::PH_SZ_LO;
      msp_pkg::PH_SZ_LO:  phase_next = msp_pkg::PH_SZ_HI;
      msp_pkg::PH_SZ_HI: begin
        phase_next = (size_full == 16'd0) ? msp_pkg::PH_CRC : msp_pkg::PH_PAYLOAD;
      end
      msp_pkg::PH_PAYLOAD: begin
        if (pos_inc >= size) phase_next = msp_pkg::PH_CRC;
      end
      msp_pkg::PH_CRC: phase_next = msp_pkg::PH_IDLE;
      default:         phase_next = msp_pkg::PH_IDLE;
    endcase
  end

  // A good-CRC frame becomes a job when its command, size and aux channel qualify.
  // The status check wins when both command codes are equal.
  always_comb begin
    job_push  = 1'b0;
    job.kind  = msp_pkg::EV_ARMED;
    job.level = armed_bit;
    if (accept && (phase == msp_pkg::PH_CRC) && crc_ok) begin
      if (cmd == cfg.status_command) begin
        job_push = (size >= msp_pkg::STATUS_MIN_SIZE);
      end else if (cmd == cfg.rc_command) begin
        job.kind  = msp_pkg::EV_AUX;
        job.level = (aux_word > msp_pkg::AUX_THRESHOLD);
        job_push  = (cfg.aux_channel != 4'd0) && (size >= rc_min_size);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= msp_pkg::PH_IDLE;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      case (phase)
        msp_pkg::PH_FLAG: crc <= msp_pkg::crc8_step(8'd0, rx_byte);
        msp_pkg::PH_CMD_LO: begin
          cmd[7:0] <= rx_byte;
          crc      <= msp_pkg::crc8_step(crc, rx_byte);
        end
        msp_pkg::PH_CMD_HI: begin
          cmd[15:8] <= rx_byte;
          crc       <= msp_pkg::crc8_step(crc, rx_byte);
        end
        msp_pkg::PH_SZ_LO: begin
          size[7:0] <= rx_byte;
          crc       <= msp_pkg::crc8_step(crc, rx_byte);
        end
        msp_pkg::PH_SZ_HI: begin
          size[15:8] <= rx_byte;
          crc        <= msp_pkg::crc8_step(crc, rx_byte);
          pos        <= 16'd0;
        end
        msp_pkg::PH_PAYLOAD: begin
          crc <= msp_pkg::crc8_step(crc, rx_byte);
          pos <= pos_inc;
          if (pos == msp_pkg::ARMED_BYTE_POS) armed_bit <= rx_byte[0];
          if (in_word_range) begin
            if (pos_off[0]) words[pos_off[4:1]][15:8] <= rx_byte;
            else            words[pos_off[4:1]][7:0]  <= rx_byte;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> src/msp_job_queue.sv
module msp_job_queue #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= wdata;
  end

endmodule

>>> src/msp_back.sv
module msp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  input  msp_pkg::job_t job,
  output logic          job_take,
  input  logic          aux_clear,
  output logic          empty,
  input  logic          pop,
  output logic          event_kind,
  output logic          new_level,
  output logic          armed_since_boot
);

  logic armed_level;
  logic armed_seen;
  logic aux_level;
  logic out_valid;
  logic emit;
  logic slot_free;
  logic seen_next;

  assign emit      = (job.kind == msp_pkg::EV_AUX) ? (job.level != aux_level)
                                                   : (job.level != armed_level);
  assign slot_free = !out_valid || pop;
  assign job_take  = job_valid && (!emit || slot_free);
  assign seen_next = armed_seen || ((job.kind == msp_pkg::EV_ARMED) && job.level);
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      armed_level <= 1'b0;
      armed_seen  <= 1'b0;
      aux_level   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (pop && out_valid) out_valid <= 1'b0;
      if (job_take) begin
        armed_seen <= seen_next;
        if (emit) begin
          out_valid <= 1'b1;
          if (job.kind == msp_pkg::EV_AUX) aux_level <= job.level;
          else                             armed_level <= job.level;
        end
      end
      if (aux_clear) aux_level <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take && emit) begin
      event_kind       <= job.kind;
      new_level        <= job.level;
      armed_since_boot <= seen_next;
    end
  end

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (job_take && emit) |=> out_valid)
    else $error("decoded level change did not produce a result");

  a_seen_sticky: assert property (@(posedge clk) disable iff (rst)
    armed_seen |=> armed_seen)
    else $error("armed-since-boot flag cleared");

  a_armed_implies_seen: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_kind == msp_pkg::EV_ARMED) && new_level) |-> armed_since_boot)
    else $error("armed result without armed-since-boot flag");

endmodule

>>> src/msp_v2_frame_receiver_core.sv
// Receiver for MSP v2 response frames. Received bytes are pushed one per cycle
// on rx_byte; the parser checks the '$' 'X' '>' header, collects the command
// and size, runs the CRC-8 DVB-S2 over flag through payload and keeps the few
// payload bytes that decoding needs. A frame with a good CRC is decoded as a
// status response (armed is bit 0 of payload byte 6, size at least 10) or as an
// RC channels response (the word of channel 3 + aux_channel compared against
// 1500). An item appears on the result side only when the armed level or the
// aux switch level changes, and it carries the sticky armed-since-boot flag.
// The parser never stalls on a byte of its own, so bytes may be pushed back to
// back; a byte is held off (full high) only when the two-entry job queue
// between the parser and the event unit is full, which happens only while
// results are not being popped. The result side holds one item. Configuration
// writes take effect at the next edge; writing a new aux channel clears the
// aux level without producing an item.
module msp_v2_frame_receiver_core #(
  parameter int JOB_QUEUE_DEPTH = msp_pkg::JOB_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [7:0]                      rx_byte,
  output logic                            empty,
  input  logic                            pop,
  output logic                            event_kind,
  output logic                            new_level,
  output logic                            armed_since_boot,
  input  logic                            cfg_write,
  input  logic [msp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [msp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  msp_pkg::cfg_t cfg;
  msp_pkg::job_t front_job;
  msp_pkg::job_t back_job;
  logic          accept;
  logic          job_push;
  logic          job_empty;
  logic          job_take;
  logic          aux_clear;

  // The parser only runs when the queue has room, so a job it produces is
  // never dropped.
  assign accept = push && !full;

  // A write of a different aux channel drops the remembered aux level.
  assign aux_clear = cfg_write && (cfg_index == msp_pkg::REG_AUX_CHANNEL) &&
                     (cfg_data[3:0] != cfg.aux_channel);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.aux_channel    <= msp_pkg::AUX_CHANNEL_RESET;
      cfg.status_command <= msp_pkg::STATUS_COMMAND_RESET;
      cfg.rc_command     <= msp_pkg::RC_COMMAND_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        msp_pkg::REG_AUX_CHANNEL:    cfg.aux_channel    <= cfg_data[3:0];
        msp_pkg::REG_STATUS_COMMAND: cfg.status_command <= cfg_data;
        msp_pkg::REG_RC_COMMAND:     cfg.rc_command     <= cfg_data;
        default: ;
      endcase
    end
  end

  msp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .rx_byte  (rx_byte),
    .cfg      (cfg),
    .job_push (job_push),
    .job      (front_job)
  );

  msp_job_queue #(
    .WIDTH ($bits(msp_pkg::job_t)),
    .DEPTH (JOB_QUEUE_DEPTH)
  ) u_job_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (front_job),
    .full  (full),
    .pop   (job_take),
    .rdata (back_job),
    .empty (job_empty)
  );

  msp_back u_back (
    .clk              (clk),
    .rst              (rst),
    .job_valid        (!job_empty),
    .job              (back_job),
    .job_take         (job_take),
    .aux_clear        (aux_clear),
    .empty            (empty),
    .pop              (pop),
    .event_kind       (event_kind),
    .new_level        (new_level),
    .armed_since_boot (armed_since_boot)
  );

endmodule
